// ----- src/mtc_pkg.sv -----
// shared constants and case tables for the marching tetrahedra cell core
package mtc_pkg;

  localparam int COORD_BITS = 16;
  localparam int VALUE_BITS = 16;

  localparam int LANES       = 9;               // three corners times three axes
  localparam int SLOT_W      = 16;
  localparam int CORNER_W    = 3 * SLOT_W;
  localparam int VERTEX_W    = 4 * SLOT_W;
  localparam int VALUE_LSB   = 3 * SLOT_W;

  localparam int D_SIGNED_W  = VALUE_BITS + 1;  // sa - sb
  localparam int AD_W        = VALUE_BITS + 1;  // |sa - sb|
  localparam int DX_W        = COORD_BITS + 1;  // pb - pa
  localparam int PROD_W      = VALUE_BITS + DX_W;
  localparam int AN_W        = VALUE_BITS + COORD_BITS;
  localparam int N_W         = AN_W + 2;        // 2*an + ad
  localparam int DEN_W       = AD_W + 1;        // 2*ad
  localparam int REM_W       = DEN_W + 1;
  localparam int QB          = COORD_BITS + 1;  // quotient bits
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES  = (QB + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SUM_W       = COORD_BITS + 2;
  localparam int THR_W       = 16;
  localparam int CMP_W       = (AD_W > THR_W) ? AD_W : THR_W;

  localparam int ADDR_W      = 3;
  localparam logic [ADDR_W-1:0] ADDR_EQUAL_THRESHOLD = 3'd0;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET      = 16'd1;

  // edge codes: 0=01 1=02 2=03 3=12 4=13 5=23
  localparam logic [1:0] EDGE_LO [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] EDGE_HI [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  localparam logic [1:0] CASE_COUNT [16] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0
  };

  localparam logic [2:0] CASE_EDGE [16][6] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd4, 3'd3, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd4, 3'd1, 3'd1, 3'd4, 3'd3},
    '{3'd1, 3'd3, 3'd5, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd0, 3'd3, 3'd3, 3'd5, 3'd2},
    '{3'd0, 3'd4, 3'd1, 3'd4, 3'd5, 3'd1},
    '{3'd2, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0},
    '{3'd4, 3'd2, 3'd5, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd4, 3'd4, 3'd1, 3'd5},
    '{3'd2, 3'd3, 3'd0, 3'd3, 3'd2, 3'd5},
    '{3'd3, 3'd1, 3'd5, 3'd0, 3'd0, 3'd0},
    '{3'd4, 3'd2, 3'd1, 3'd1, 3'd3, 3'd4},
    '{3'd0, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  // one lane of the pipelined restoring divider
  typedef struct packed {
    logic [REM_W-1:0]             rem;
    logic [N_W-1:0]               num;
    logic [QB-1:0]                quo;
    logic [DEN_W-1:0]             den;
    logic                         neg;
    logic signed [COORD_BITS-1:0] pa;
  } div_lane_t;

endpackage

// ----- src/marching_tetrahedra_cell_core.sv -----
// marching tetrahedra cell core: case decode, zero-crossing interpolation pipeline
// triangles pass edge select, product, divider and result; a second comes the cycle after
// throughput: one triangle enters the interpolation pipeline per cycle; cells with zero or
//   one triangle are taken every cycle, a two-triangle cell holds busy as its first issues
// the interpolation uses a 17-bit restoring divider, three quotient bits per stage
// rst (synchronous) clears the sequencer, all pipeline valid bits and sets
//   equal_threshold to 1; results cannot be stalled by the receiver
module marching_tetrahedra_cell_core
  import mtc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // cell transfer
  input  logic                start,
  output logic                busy,
  input  logic [VERTEX_W-1:0] vertex_zero,
  input  logic [VERTEX_W-1:0] vertex_one,
  input  logic [VERTEX_W-1:0] vertex_two,
  input  logic [VERTEX_W-1:0] vertex_three,
  // triangle transfer
  output logic                done,
  output logic [CORNER_W-1:0] corner_first,
  output logic [CORNER_W-1:0] corner_second,
  output logic [CORNER_W-1:0] corner_third,
  output logic                last_triangle,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // ---------------------------------------------------------------- registers
  logic [THR_W-1:0] equal_threshold;
  logic             thr_sel;

  // register select on the word address, byte lane bits ignored
  assign thr_sel = (paddr[ADDR_W-1:2] == ADDR_EQUAL_THRESHOLD[ADDR_W-1:2]);

  assign pready = 1'b1;
  assign prdata = thr_sel ? 32'(equal_threshold) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && thr_sel) begin
      equal_threshold <= pwdata[THR_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  // a cell is held while its triangles issue; busy only covers the first
  // triangle of a two-triangle case
  logic [VERTEX_W-1:0] vtx [4];
  logic [3:0]          case_idx;
  logic                pending;
  logic                tri_sel;
  logic                accept;
  logic                issue;
  logic                issue_last;
  logic [3:0]          case_idx_next;

  assign busy       = pending && !tri_sel && (CASE_COUNT[case_idx] == 2'd2);
  assign accept     = start && !busy;
  assign issue      = pending && (CASE_COUNT[case_idx] != 2'd0);
  assign issue_last = !busy;

  // a vertex is inside when its value is negative
  assign case_idx_next = {vertex_three[VALUE_LSB + VALUE_BITS - 1],
                          vertex_two[VALUE_LSB + VALUE_BITS - 1],
                          vertex_one[VALUE_LSB + VALUE_BITS - 1],
                          vertex_zero[VALUE_LSB + VALUE_BITS - 1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      tri_sel <= 1'b0;
    end else if (accept) begin
      pending <= 1'b1;
      tri_sel <= 1'b0;
    end else if (busy) begin
      tri_sel <= 1'b1;
    end else begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vtx[0]   <= vertex_zero;
      vtx[1]   <= vertex_one;
      vtx[2]   <= vertex_two;
      vtx[3]   <= vertex_three;
      case_idx <= case_idx_next;
    end
  end

  // ---------------------------------------------------------------- edge select
  // each lane picks its corner's edge, endpoints and axis; midpoint decision
  logic signed [VALUE_BITS-1:0] s1_sa  [LANES];
  logic signed [D_SIGNED_W-1:0] s1_d   [LANES];
  logic signed [COORD_BITS-1:0] s1_pa  [LANES];
  logic signed [DX_W-1:0]       s1_dx  [LANES];
  logic                         s1_mid [LANES];
  logic                         s1_valid;
  logic                         s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0]                   slot;
    logic [2:0]                   edge_code;
    logic [VERTEX_W-1:0]          va;
    logic [VERTEX_W-1:0]          vb;
    logic signed [VALUE_BITS-1:0] sa;
    logic signed [VALUE_BITS-1:0] sb;
    logic signed [D_SIGNED_W-1:0] dd;
    logic [AD_W-1:0]              ad;
    logic signed [COORD_BITS-1:0] pa;
    logic signed [COORD_BITS-1:0] pb;
    s1_last <= issue_last;
    for (int l = 0; l < LANES; l++) begin
      slot      = 3'(tri_sel ? 3 + l / 3 : l / 3);
      edge_code = CASE_EDGE[case_idx][slot];
      va        = vtx[EDGE_LO[edge_code]];
      vb        = vtx[EDGE_HI[edge_code]];
      sa        = va[VALUE_LSB +: VALUE_BITS];
      sb        = vb[VALUE_LSB +: VALUE_BITS];
      dd        = D_SIGNED_W'(sa) - D_SIGNED_W'(sb);
      ad        = dd[D_SIGNED_W-1] ? AD_W'(-dd) : AD_W'(dd);
      pa        = va[SLOT_W * (l % 3) +: COORD_BITS];
      pb        = vb[SLOT_W * (l % 3) +: COORD_BITS];
      s1_sa[l]  <= sa;
      s1_d[l]   <= dd;
      s1_pa[l]  <= pa;
      s1_dx[l]  <= DX_W'(pb) - DX_W'(pa);
      s1_mid[l] <= (dd == '0) || (CMP_W'(ad) < CMP_W'(equal_threshold));
    end
  end

  // ---------------------------------------------------------------- product
  // numerator magnitude and sign; the midpoint case divides |dx| by two
  logic [AN_W-1:0]              s2_an  [LANES];
  logic [AD_W-1:0]              s2_ad  [LANES];
  logic                         s2_neg [LANES];
  logic signed [COORD_BITS-1:0] s2_pa  [LANES];
  logic                         s2_valid;
  logic                         s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [PROD_W-1:0] prod;
    s2_last <= s1_last;
    for (int l = 0; l < LANES; l++) begin
      prod      = PROD_W'(s1_sa[l]) * PROD_W'(s1_dx[l]);
      s2_pa[l]  <= s1_pa[l];
      if (s1_mid[l]) begin
        s2_an[l]  <= s1_dx[l][DX_W-1] ? AN_W'(-s1_dx[l]) : AN_W'(s1_dx[l]);
        s2_ad[l]  <= AD_W'(2);
        s2_neg[l] <= s1_dx[l][DX_W-1];
      end else begin
        s2_an[l]  <= prod[PROD_W-1] ? AN_W'(-prod) : AN_W'(prod);
        s2_ad[l]  <= s1_d[l][D_SIGNED_W-1] ? AD_W'(-s1_d[l]) : AD_W'(s1_d[l]);
        s2_neg[l] <= prod[PROD_W-1] ^ s1_d[l][D_SIGNED_W-1];
      end
    end
  end

  // ---------------------------------------------------------------- divider
  // round(an / ad) = floor((2an + ad) / 2ad), restoring, msb first
  div_lane_t dv       [DIV_STAGES+1][LANES];
  div_lane_t dv_next  [DIV_STAGES][LANES];
  logic      dv_valid [DIV_STAGES+1];
  logic      dv_last  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    logic [N_W-1:0] num;
    for (int l = 0; l < LANES; l++) begin
      num           = {s2_an[l], 1'b0} + N_W'(s2_ad[l]);
      dv[0][l].num <= num;
      dv[0][l].rem <= REM_W'(num >> QB);
      dv[0][l].quo <= '0;
      dv[0][l].den <= {s2_ad[l], 1'b0};
      dv[0][l].neg <= s2_neg[l];
      dv[0][l].pa  <= s2_pa[l];
    end
    dv_last[0] <= s2_last;
  end

  always_comb begin
    logic [REM_W-1:0] trial;
    int               k;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        dv_next[s][l] = dv[s][l];
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          k = s * STEPS_PER_STAGE + j;
          if (k < QB) begin
            trial = {dv_next[s][l].rem[REM_W-2:0], dv_next[s][l].num[QB-1-k]};
            if (trial >= REM_W'(dv_next[s][l].den)) begin
              dv_next[s][l].rem          = trial - REM_W'(dv_next[s][l].den);
              dv_next[s][l].quo[QB-1-k]  = 1'b1;
            end else begin
              dv_next[s][l].rem = trial;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        dv_valid[s] <= 1'b0;
      end
    end else begin
      dv_valid[0] <= s2_valid;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_valid[s+1] <= dv_valid[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      dv[s+1]      <= dv_next[s];
      dv_last[s+1] <= dv_last[s];
    end
  end

  // ---------------------------------------------------------------- result
  // apply the sign, add the base position and clamp to the coordinate range
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (COORD_BITS - 1));

  logic signed [COORD_BITS-1:0] res [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] sum;
    last_triangle <= dv_last[DIV_STAGES];
    for (int l = 0; l < LANES; l++) begin
      qs  = dv[DIV_STAGES][l].neg ? -SUM_W'(dv[DIV_STAGES][l].quo)
                                  :  SUM_W'(dv[DIV_STAGES][l].quo);
      sum = SUM_W'(dv[DIV_STAGES][l].pa) + qs;
      if (sum > SAT_HI) begin
        res[l] <= SAT_HI[COORD_BITS-1:0];
      end else if (sum < SAT_LO) begin
        res[l] <= SAT_LO[COORD_BITS-1:0];
      end else begin
        res[l] <= sum[COORD_BITS-1:0];
      end
    end
  end

  assign corner_first  = {SLOT_W'(res[2]), SLOT_W'(res[1]), SLOT_W'(res[0])};
  assign corner_second = {SLOT_W'(res[5]), SLOT_W'(res[4]), SLOT_W'(res[3])};
  assign corner_third  = {SLOT_W'(res[8]), SLOT_W'(res[7]), SLOT_W'(res[6])};

endmodule

// ----- src/mtc_checker.sv -----
// port-level checks for the marching tetrahedra cell core
module mtc_checker
  import mtc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic last_triangle,
  input logic pready
);

  // busy covers exactly one cycle, the one after a two-triangle transfer
  a_busy_single: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
      busy |-> $past(start && !busy))
    else $error("busy without a preceding transfer");

  // the two triangles of one cell leave back to back
  a_pair: assert property (@(posedge clk) disable iff (rst)
      (done && !last_triangle) |=> (done && last_triangle))
    else $error("second triangle did not follow the first");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind marching_tetrahedra_cell_core mtc_checker u_mtc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .last_triangle (last_triangle),
  .pready        (pready)
);
